/* rtl/core/printf_integer_formatter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the integer formatter.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRINTF_INTEGER_FORMATTER_MACROS_SVH
`define PRINTF_INTEGER_FORMATTER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PIF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pif_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_pkg
// Shared codes, descriptor type and digit lookup for the integer formatter.
// ----------------------------------------------------------------------------
package pif_pkg;

    // Request kinds as they arrive on req_type
    localparam logic [2:0] KIND_CHAR = 3'd0;
    localparam logic [2:0] KIND_SDEC = 3'd1;
    localparam logic [2:0] KIND_UDEC = 3'd2;
    localparam logic [2:0] KIND_LHEX = 3'd3;
    localparam logic [2:0] KIND_UHEX = 3'd4;
    localparam logic [2:0] KIND_PTR  = 3'd5;

    // Conversion formats after classification
    localparam logic [1:0] FMT_CHAR = 2'd0;
    localparam logic [1:0] FMT_DEC  = 2'd1;
    localparam logic [1:0] FMT_HEX  = 2'd2;

    // Prefixes
    localparam logic [1:0] PFX_NONE  = 2'd0;
    localparam logic [1:0] PFX_MINUS = 2'd1;
    localparam logic [1:0] PFX_0X    = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LOWER_BASE = 8'h57;  // 'a' - 10
    localparam logic [7:0] CH_UPPER_BASE = 8'h37;  // 'A' - 10

    // Divide by ten: q = (m * RECIP10) >> DEC_SHIFT, exact for 32-bit m
    localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;
    localparam int          DEC_DIGITS = 10;

    typedef struct packed {
        logic [1:0] fmt;
        logic       upper;
        logic [1:0] pfx;
    } desc_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10)
            base = CH_ZERO;
        else if (upper)
            base = CH_UPPER_BASE;
        else
            base = CH_LOWER_BASE;
        return base + {4'd0, d};
    endfunction

endpackage

/* rtl/core/pif_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_front
// Classifies a request into a format, prefix and magnitude for the back end.
// ----------------------------------------------------------------------------
module pif_front import pif_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic [2:0]             req_type,
    input  logic [63:0]            value,
    output desc_ctrl_t             ctrl,
    output logic [VALUE_WIDTH-1:0] mag
);

    logic [31:0] low32;
    logic [31:0] neg32;

    assign low32 = value[31:0];
    assign neg32 = 32'd0 - low32;

    always_comb
    begin
        ctrl.fmt   = FMT_CHAR;
        ctrl.upper = 1'b0;
        ctrl.pfx   = PFX_NONE;
        mag        = VALUE_WIDTH'(value[7:0]);
        unique case (req_type)
            KIND_SDEC:
            begin
                ctrl.fmt = FMT_DEC;
                if (low32[31])
                begin
                    ctrl.pfx = PFX_MINUS;
                    mag      = VALUE_WIDTH'(neg32);
                end
                else
                begin
                    mag = VALUE_WIDTH'(low32);
                end
            end
            KIND_UDEC:
            begin
                ctrl.fmt = FMT_DEC;
                mag      = VALUE_WIDTH'(low32);
            end
            KIND_LHEX:
            begin
                ctrl.fmt = FMT_HEX;
                mag      = VALUE_WIDTH'(low32);
            end
            KIND_UHEX:
            begin
                ctrl.fmt   = FMT_HEX;
                ctrl.upper = 1'b1;
                mag        = VALUE_WIDTH'(low32);
            end
            KIND_PTR:
            begin
                ctrl.fmt = FMT_HEX;
                ctrl.pfx = PFX_0X;
                mag      = value[VALUE_WIDTH-1:0];
            end
            default:
            begin
                // character, and the unused kinds: low byte as is
                ctrl.fmt = FMT_CHAR;
            end
        endcase
    end

endmodule

/* rtl/core/pif_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_queue
// Two-entry queue of classified requests between front and back ends.
// ----------------------------------------------------------------------------
`include "printf_integer_formatter_macros.svh"

module pif_queue import pif_pkg::*;
#(
    parameter int WIDTH = 69
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign rdata = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    `PIF_ASSERT_SAME(a_no_overflow, push, count_reg != 2'd2, "push into full queue")
    `PIF_ASSERT_SAME(a_no_underflow, pop, count_reg != 2'd0, "pop from empty queue")
    `PIF_ASSERT_NEXT(a_push_fills, push, count_reg != 2'd0, "queue empty after push")

endmodule

/* rtl/core/pif_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pif_back
// Builds digits LSB first as the prefix starts out, then streams digits MSB first.
// ----------------------------------------------------------------------------
`include "printf_integer_formatter_macros.svh"

module pif_back import pif_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  desc_ctrl_t             q_ctrl,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    input  logic                   q_empty,
    output logic                   q_pop,
    output logic                   strobe,
    output logic [7:0]             out_char,
    output logic                   last
);

    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int DEPTH = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    desc_ctrl_t             ctrl_reg, ctrl_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [CW-1:0]          ndig_reg, ndig_next;
    logic [1:0]             pfx_cnt_reg, pfx_cnt_next;
    logic                   strobe_reg, strobe_next;
    logic                   last_reg, last_next;
    logic [7:0]             char_reg, char_next;
    logic [7:0]             buf_reg [DEPTH];
    logic                   buf_we;

    logic [63:0]            dec_prod;
    logic [28:0]            dec_quot;
    logic [31:0]            dec_rest;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] quot;
    logic [7:0]             pfx_char;
    logic [CW-1:0]          rd_cnt;
    logic [IW-1:0]          rd_idx;
    logic [IW-1:0]          wr_idx;

    // One digit per cycle: decimal by reciprocal multiply, hex by nibble shift
    assign dec_prod = {32'd0, mag_reg[31:0]} * {32'd0, RECIP10};
    assign dec_quot = dec_prod[63:DEC_SHIFT];
    assign dec_rest = mag_reg[31:0] - {dec_quot, 3'b000} - {2'b00, dec_quot, 1'b0};
    assign digit    = (ctrl_reg.fmt == FMT_HEX) ? mag_reg[3:0] : dec_rest[3:0];
    assign quot     = (ctrl_reg.fmt == FMT_HEX) ? (mag_reg >> 4)
                                                : VALUE_WIDTH'(dec_quot);

    assign pfx_char = (ctrl_reg.pfx == PFX_MINUS) ? CH_MINUS
                    : ((pfx_cnt_reg == 2'd2) ? CH_ZERO : CH_X);

    assign rd_cnt = ndig_reg - CW'(1);
    assign rd_idx = rd_cnt[IW-1:0];
    assign wr_idx = ndig_reg[IW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        ctrl_next    = ctrl_reg;
        mag_next     = mag_reg;
        ndig_next    = ndig_reg;
        pfx_cnt_next = pfx_cnt_reg;
        strobe_next  = 1'b0;
        last_next    = 1'b0;
        char_next    = char_reg;
        q_pop        = 1'b0;
        buf_we       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_ctrl.fmt == FMT_CHAR)
                    begin
                        strobe_next = 1'b1;
                        char_next   = q_mag[7:0];
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        ctrl_next  = q_ctrl;
                        mag_next   = q_mag;
                        ndig_next  = '0;
                        state_next = S_GEN;
                        if (q_ctrl.pfx == PFX_MINUS)
                            pfx_cnt_next = 2'd1;
                        else if (q_ctrl.pfx == PFX_0X)
                            pfx_cnt_next = 2'd2;
                        else
                            pfx_cnt_next = 2'd0;
                    end
                end
            end
            S_GEN:
            begin
                buf_we    = 1'b1;
                ndig_next = ndig_reg + CW'(1);
                mag_next  = quot;
                if (quot == '0)
                    state_next = S_EMIT;
                // prefix goes out while the digits are still being worked out
                if (pfx_cnt_reg != 2'd0)
                begin
                    strobe_next  = 1'b1;
                    char_next    = pfx_char;
                    pfx_cnt_next = pfx_cnt_reg - 2'd1;
                end
            end
            S_EMIT:
            begin
                strobe_next = 1'b1;
                if (pfx_cnt_reg != 2'd0)
                begin
                    char_next    = pfx_char;
                    pfx_cnt_next = pfx_cnt_reg - 2'd1;
                end
                else
                begin
                    char_next = buf_reg[rd_idx];
                    ndig_next = rd_cnt;
                    if (ndig_reg == CW'(1))
                    begin
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        mag_reg  <= mag_next;
        char_reg <= char_next;
        if (buf_we)
            buf_reg[wr_idx] <= digit_char(digit, ctrl_reg.upper);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ndig_reg    <= '0;
            pfx_cnt_reg <= 2'd0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ndig_reg    <= ndig_next;
            pfx_cnt_reg <= pfx_cnt_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
        end
    end

    assign strobe   = strobe_reg;
    assign out_char = char_reg;
    assign last     = last_reg;

    `PIF_ASSERT_SAME(a_gen_room, state_reg == S_GEN, ndig_reg < CW'(DEPTH), "digit buffer overrun")
    `PIF_ASSERT_SAME(a_emit_has_digit, state_reg == S_EMIT, ndig_reg != '0, "emit with no digits")
    `PIF_ASSERT_SAME(a_last_marks_end, last_reg, strobe_reg && state_reg == S_IDLE, "stray last flag")

endmodule

/* rtl/core/printf_integer_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_integer_formatter
// Turns a conversion request into its ASCII characters, one per strobe.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  request   start in, busy out        req_type[2:0], value[63:0]
//  result    strobe out (no stall)     out_char[7:0], last
//
//  A character request goes straight from the queue to the output register.
//  A numeric request is loaded, its digits are generated least significant
//  first (digit recurrence through a single divide-by-ten multiplier or a
//  nibble shift) into a buffer, then streamed out most significant first.
//  Sign and "0x" prefixes start going out while digits are still being
//  generated. Reset is asynchronous, active low; it empties the queue and
//  idles the back end. The receiver cannot stall: busy rises only when the
//  two-entry queue is full.
//
// ----------------------------------------------------------------------------
module printf_integer_formatter import pif_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [63:0] value,
    output logic        strobe,
    output logic [7:0]  out_char,
    output logic        last
);

    // Queue entry: control descriptor above the magnitude
    localparam int QW = $bits(desc_ctrl_t) + VALUE_WIDTH;

    desc_ctrl_t             f_ctrl;
    logic [VALUE_WIDTH-1:0] f_mag;
    desc_ctrl_t             q_ctrl;
    logic [VALUE_WIDTH-1:0] q_mag;
    logic [QW-1:0]          q_rdata;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   push;

    // Accept an item whenever the queue has room
    assign push = start && !q_full;
    assign busy = q_full;

    pif_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .req_type (req_type),
        .value    (value),
        .ctrl     (f_ctrl),
        .mag      (f_mag)
    );

    pif_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_ctrl, f_mag}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // Split the entry back into descriptor and magnitude
    assign q_ctrl = q_rdata[QW-1:VALUE_WIDTH];
    assign q_mag  = q_rdata[VALUE_WIDTH-1:0];

    pif_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_ctrl   (q_ctrl),
        .q_mag    (q_mag),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .strobe   (strobe),
        .out_char (out_char),
        .last     (last)
    );

endmodule

/* tb/printf_integer_formatter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_integer_formatter_tb
// Self-checking bench for the integer formatter. Conversion requests are
// queued up front (a directed set of corner values, then a random mix) and
// fed through the start/busy handshake with random gaps. Every accepted
// request is expanded into its expected characters by a local formatter, and
// each strobed character is checked, in order, against the oldest one.
// ----------------------------------------------------------------------------
module printf_integer_formatter_tb;
    import pif_pkg::*;

    localparam int PTR_WIDTH    = 64;
    localparam int RANDOM_ITEMS = 206;
    localparam int SETTLE_CYCLES = 50;     // longer than the slowest pointer
    localparam int IDLE_LIMIT   = 2000;    // cycles with no handshake at all

    // Selector codes that the block has no kind for; they behave as a char
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] operand;
    } conv_req_t;

    typedef struct {
        logic [7:0] ch;
        logic       last_flag;
    } fmt_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  req_type = KIND_CHAR;
    logic [63:0] value = 64'd0;
    logic        busy;
    logic        strobe;
    logic [7:0]  out_char;
    logic        last;

    conv_req_t pending_reqs[$];     // requests not yet taken by the block
    fmt_char_t expected_chars[$];   // characters still owed, in print order

    int fail_count = 0;
    int gap_left   = 0;
    int calm_left  = 0;
    int gap_roll   = 0;
    int idle_cycles = 0;

    printf_integer_formatter #(
        .VALUE_WIDTH (PTR_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .value    (value),
        .strobe   (strobe),
        .out_char (out_char),
        .last     (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Append the digits of mag, most significant first, with no leading zeros
    function automatic void push_digits(input logic [63:0] mag, input bit hex,
                                        input bit upper);
        string      lower_set = "0123456789abcdef";
        string      upper_set = "0123456789ABCDEF";
        logic [7:0] rev[$];
        logic [3:0] d;
        do
        begin
            if (hex)
            begin
                d   = mag[3:0];
                mag = mag >> 4;
                rev.push_back(upper ? upper_set[d] : lower_set[d]);
            end
            else
            begin
                d   = 4'(mag % 64'd10);
                mag = mag / 64'd10;
                rev.push_back(CH_ZERO + 8'(d));
            end
        end
        while (mag != 64'd0);
        while (rev.size() > 0)
            expected_chars.push_back('{rev.pop_back(), 1'b0});
    endfunction

    // Expand one accepted request into the characters it must print
    function automatic void predict_conversion(input logic [2:0] kind,
                                               input logic [63:0] operand);
        logic [31:0] low_word;
        logic [63:0] ptr_mask;
        low_word = operand[31:0];
        ptr_mask = {64{1'b1}} >> (64 - PTR_WIDTH);
        case (kind)
            KIND_SDEC:
            begin
                if (low_word[31])
                begin
                    // magnitude in unsigned arithmetic, so the most negative
                    // value prints in full
                    expected_chars.push_back('{CH_MINUS, 1'b0});
                    push_digits({32'd0, 32'd0 - low_word}, 1'b0, 1'b0);
                end
                else
                    push_digits({32'd0, low_word}, 1'b0, 1'b0);
            end
            KIND_UDEC: push_digits({32'd0, low_word}, 1'b0, 1'b0);
            KIND_LHEX: push_digits({32'd0, low_word}, 1'b1, 1'b0);
            KIND_UHEX: push_digits({32'd0, low_word}, 1'b1, 1'b1);
            KIND_PTR:
            begin
                expected_chars.push_back('{CH_ZERO, 1'b0});
                expected_chars.push_back('{CH_X, 1'b0});
                push_digits(operand & ptr_mask, 1'b1, 1'b0);
            end
            default: expected_chars.push_back('{operand[7:0], 1'b0});
        endcase
        expected_chars[expected_chars.size() - 1].last_flag = 1'b1;
    endfunction

    function automatic void queue_req(input logic [2:0] kind, input logic [63:0] operand);
        pending_reqs.push_back('{kind, operand});
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the head of the pending queue and hold it until busy is
    // low at an edge. After each accepted item draw an idle gap: mostly none
    // or short, now and then long, with calm stretches of back-to-back items.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!(start && busy))
        begin
            if (start)
            begin
                void'(pending_reqs.pop_front());
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else
                begin
                    gap_roll = $urandom_range(0, 99);
                    if (gap_roll < 8)
                    begin
                        calm_left = $urandom_range(5, 20);
                        gap_left  = 0;
                    end
                    else if (gap_roll < 55)
                        gap_left = 0;
                    else if (gap_roll < 92)
                        gap_left = $urandom_range(1, 4);
                    else
                        gap_left = $urandom_range(10, 40);
                end
            end
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_reqs.size() > 0)
            begin
                start    <= 1'b1;
                req_type <= pending_reqs[0].kind;
                value    <= pending_reqs[0].operand;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the strobed character against the oldest expectation,
    // then record any request taken at this edge. Checking first keeps a
    // stray strobe from ever matching the item accepted in the same cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        fmt_char_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              out_char, last));
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h",
                                                  out_char, want.ch));
                    if (last !== want.last_flag)
                        report_mismatch($sformatf("last %0b, wanted %0b on 0x%02h",
                                                  last, want.last_flag, want.ch));
                end
            end
            if (start && !busy)
                predict_conversion(req_type, value);
        end
    end

    // Watchdog: drop the run if neither side shakes hands for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [2:0]  kind;
        logic [63:0] operand;
        int          roll;
        int          shape;

        // Directed: every kind, zero operands, field extremes, junk in the
        // upper word, the spare selectors and the most negative signed value
        queue_req(KIND_CHAR, 64'd0);
        queue_req(KIND_CHAR, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(KIND_CHAR, 64'h0000_0000_0000_0025);
        queue_req(KIND_SPARE_LO, 64'hA5A5_5A5A_0000_0041);
        queue_req(KIND_SPARE_HI, 64'h8000_0000_0000_00FF);
        queue_req(KIND_SDEC, 64'd0);
        queue_req(KIND_SDEC, 64'h0000_0000_7FFF_FFFF);
        queue_req(KIND_SDEC, 64'h0000_0000_8000_0000);
        queue_req(KIND_SDEC, 64'h0000_0000_FFFF_FFFF);
        queue_req(KIND_SDEC, 64'hFFFF_FFFF_0000_0005);
        queue_req(KIND_UDEC, 64'd0);
        queue_req(KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(KIND_UDEC, 64'd9);
        queue_req(KIND_UDEC, 64'd10);
        queue_req(KIND_LHEX, 64'd0);
        queue_req(KIND_LHEX, 64'h1234_5678_DEAD_BEEF);
        queue_req(KIND_LHEX, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(KIND_UHEX, 64'd0);
        queue_req(KIND_UHEX, 64'h0000_0000_ABCD_EF01);
        queue_req(KIND_UHEX, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(KIND_PTR, 64'd0);
        queue_req(KIND_PTR, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(KIND_PTR, 64'd1);
        queue_req(KIND_PTR, 64'h8000_0000_0000_0000);

        // Random: mostly numeric kinds, full-width operands mixed with short
        // magnitudes so that every digit count turns up
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                kind = KIND_CHAR;
            else if (roll < 14)
                kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            else
                kind = 3'($urandom_range(KIND_SDEC, KIND_PTR));
            operand = {$urandom, $urandom};
            shape = $urandom_range(0, 3);
            if (shape == 0)
                operand = operand >> $urandom_range(0, 63);
            else if (shape == 1)
            begin
                if (kind == KIND_SDEC)
                    operand[31:0] = 32'd0 - 32'($urandom_range(1, 1000));
                else
                    operand[31:0] = 32'($urandom_range(0, 20));
            end
            queue_req(kind, operand);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample between edges so the driver and monitor have both settled
        while (pending_reqs.size() > 0 || expected_chars.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
